FILE: hdl/tdq_pkg.sv
// tdq_pkg: shared widths, reset values, register codes and structs
// for the tail-drop queue delay model core; no dependencies
package tdq_pkg;

	// defaults for the top-level parameters
	localparam int RING_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF  = 48;

	// fixed field widths
	localparam int CFG_W   = 32;
	localparam int CAP_W   = 7;
	localparam int SEND_W  = 48;
	localparam int DELAY_W = 48;
	localparam int SUM_W   = 56;
	localparam int COUNT_W = 32;
	localparam int OCC_W   = 7;
	localparam int FIX_W   = CFG_W + 2;

	// configuration reset values
	localparam logic [CFG_W-1:0] INGRESS_RST  = 32'd0;
	localparam logic [CFG_W-1:0] SERVICE_RST  = 32'd1;
	localparam logic [CFG_W-1:0] EGRESS_RST   = 32'd0;
	localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd50;

	// configuration register indices
	typedef enum logic [1:0] {
		CFG_INGRESS  = 2'd0,
		CFG_SERVICE  = 2'd1,
		CFG_EGRESS   = 2'd2,
		CFG_CAPACITY = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] ingress;
		logic [CFG_W-1:0] service;
		logic [CFG_W-1:0] egress;
		logic [CAP_W-1:0] capacity;
	} cfg_t;

	// one statistics update per finished item
	typedef struct packed {
		logic               fire;
		logic               accepted;
		logic [DELAY_W-1:0] qd;
		logic [DELAY_W-1:0] e2e;
	} stat_upd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] delivered;
		logic [COUNT_W-1:0] dropped;
		logic [SUM_W-1:0]   qd_sum;
		logic [SUM_W-1:0]   e2e_sum;
	} stat_t;

endpackage

FILE: hdl/tdq_if.sv
// tdq_if: valid/ready channel interfaces for packet items and result items
// depends on tdq_pkg for field widths
interface tdq_in_if;
	logic                       valid;
	logic                       ready;
	logic [tdq_pkg::SEND_W-1:0] send_time;

	modport source (output valid, output send_time, input ready);
	modport sink (input valid, input send_time, output ready);
endinterface

interface tdq_out_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [tdq_pkg::DELAY_W-1:0] queue_delay;
	logic [tdq_pkg::DELAY_W-1:0] end_to_end_delay;
	logic [tdq_pkg::OCC_W-1:0]   occupancy;
	logic [tdq_pkg::COUNT_W-1:0] delivered_count;
	logic [tdq_pkg::COUNT_W-1:0] dropped_count;
	logic [tdq_pkg::OCC_W-1:0]   peak_occupancy;
	logic [tdq_pkg::SUM_W-1:0]   total_queue_delay;
	logic [tdq_pkg::SUM_W-1:0]   total_end_to_end_delay;

	modport source (output valid, output accepted, output queue_delay,
		output end_to_end_delay, output occupancy, output delivered_count,
		output dropped_count, output peak_occupancy, output total_queue_delay,
		output total_end_to_end_delay, input ready);
	modport sink (input valid, input accepted, input queue_delay,
		input end_to_end_delay, input occupancy, input delivered_count,
		input dropped_count, input peak_occupancy, input total_queue_delay,
		input total_end_to_end_delay, output ready);
endinterface

FILE: hdl/tdq_ring.sv
// tdq_ring: departure-time ring storage, one write and one read port,
// registered read data; no dependencies
module tdq_ring #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/tdq_cfg_regs.sv
// tdq_cfg_regs: configuration register file behind the plain write port
// depends on tdq_pkg
module tdq_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  tdq_pkg::cfg_idx_t           index,
	input  logic [tdq_pkg::CFG_W-1:0]   wdata,
	output tdq_pkg::cfg_t               cfg
);

	tdq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ingress  <= tdq_pkg::INGRESS_RST;
			cfg_q.service  <= tdq_pkg::SERVICE_RST;
			cfg_q.egress   <= tdq_pkg::EGRESS_RST;
			cfg_q.capacity <= tdq_pkg::CAPACITY_RST;
		end else if (we) begin
			unique case (index)
				tdq_pkg::CFG_INGRESS:  cfg_q.ingress  <= wdata;
				tdq_pkg::CFG_SERVICE:  cfg_q.service  <= wdata;
				tdq_pkg::CFG_EGRESS:   cfg_q.egress   <= wdata;
				tdq_pkg::CFG_CAPACITY: cfg_q.capacity <= wdata[tdq_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/tdq_stats.sv
// tdq_stats: saturating running counts, delay sums and peak occupancy
// depends on tdq_pkg
module tdq_stats #(
	parameter int OCC_BITS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdq_pkg::stat_upd_t    upd,
	input  logic [OCC_BITS-1:0]   occ,
	output tdq_pkg::stat_t        nxt,
	output logic [OCC_BITS-1:0]   peak_nxt
);

	localparam int SW = tdq_pkg::SUM_W;

	tdq_pkg::stat_t       stat_q;
	logic [OCC_BITS-1:0]  peak_q;
	logic [SW:0]          qd_sum_w;
	logic [SW:0]          e2e_sum_w;

	// sums never exceed 2^56-1 and addends stay below 2^48, so a carry out means overflow
	assign qd_sum_w  = {1'b0, stat_q.qd_sum} + (SW+1)'(upd.qd);
	assign e2e_sum_w = {1'b0, stat_q.e2e_sum} + (SW+1)'(upd.e2e);

	always_comb begin
		nxt      = stat_q;
		peak_nxt = (occ > peak_q) ? occ : peak_q;
		if (upd.accepted) begin
			if (stat_q.delivered != '1) begin
				nxt.delivered = stat_q.delivered + tdq_pkg::COUNT_W'(1);
			end
			nxt.qd_sum  = qd_sum_w[SW] ? '1 : qd_sum_w[SW-1:0];
			nxt.e2e_sum = e2e_sum_w[SW] ? '1 : e2e_sum_w[SW-1:0];
		end else if (stat_q.dropped != '1) begin
			nxt.dropped = stat_q.dropped + tdq_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
			peak_q <= '0;
		end else if (upd.fire) begin
			stat_q <= nxt;
			peak_q <= peak_nxt;
		end
	end

endmodule

FILE: hdl/tail_drop_queue_delay_model_core.sv
// tail_drop_queue_delay_model_core: top level, item sequencer around the departure ring
// depends on tdq_pkg, tdq_if, tdq_ring, tdq_cfg_regs, tdq_stats
// sequence: an accepted item passes through scan, which retires the stored departures that
// are due (one per ring read), then finish, then emit, which loads the output register
// one item is in flight at a time; the next item is taken as the result is loaded
// reset: arst_n clears pointers, occupancy, statistics and the output valid at once;
// ring contents are left as they are and no clearing pass is run
module tail_drop_queue_delay_model_core #(
	parameter int RING_DEPTH = tdq_pkg::RING_DEPTH_DEF,
	parameter int TIME_BITS  = tdq_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tdq_in_if.sink                      pkt,
	tdq_out_if.source                   res,
	input  logic                        cfg_we,
	input  tdq_pkg::cfg_idx_t           cfg_index,
	input  logic [tdq_pkg::CFG_W-1:0]   cfg_wdata
);

	// pointer, occupancy and working widths
	localparam int AW    = $clog2(RING_DEPTH);
	localparam int QC_W  = $clog2(RING_DEPTH + 1);
	localparam int CW    = (QC_W > tdq_pkg::CAP_W) ? QC_W : tdq_pkg::CAP_W;
	localparam int ARR_W = ((TIME_BITS > tdq_pkg::SEND_W) ? TIME_BITS : tdq_pkg::SEND_W) + 1;
	localparam int DIFF_W = (TIME_BITS > tdq_pkg::DELAY_W) ? TIME_BITS : tdq_pkg::DELAY_W;
	localparam int DW    = tdq_pkg::DELAY_W;

	localparam logic [ARR_W-1:0]  TMAX_A = ARR_W'({TIME_BITS{1'b1}});
	localparam logic [DIFF_W-1:0] DMAX_D = DIFF_W'({DW{1'b1}});

	// idle -> scan (retire due departures) -> finish (decide, push) -> emit (load result)
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t state_q;

	tdq_pkg::cfg_t       cfg;
	tdq_pkg::stat_upd_t  upd;
	tdq_pkg::stat_t      stat_nxt;
	logic [QC_W-1:0]     peak_nxt;

	// control state
	logic [AW-1:0]        head_q;
	logic [AW-1:0]        tail_q;
	logic [QC_W-1:0]      count_q;
	logic [TIME_BITS-1:0] last_q;
	logic                 out_valid_q;

	// per-item pipeline registers
	logic [TIME_BITS-1:0]      arr_s1;
	logic [tdq_pkg::FIX_W-1:0] fixed_s1;
	logic [tdq_pkg::CFG_W-1:0] svc_s1;
	logic [QC_W-1:0]           cap_s1;
	logic [TIME_BITS-1:0]      start_s2;
	logic [DW-1:0]             qd_s2;
	logic                      drop_s2;
	logic                      acc_s3;
	logic [DW-1:0]             qd_s3;
	logic [DW-1:0]             e2e_s3;

	// result register
	logic                          acc_q;
	logic [DW-1:0]                 qd_q;
	logic [DW-1:0]                 e2e_q;
	logic [tdq_pkg::OCC_W-1:0]     occ_q;
	logic [tdq_pkg::OCC_W-1:0]     peak_q;
	tdq_pkg::stat_t                stat_q;

	// combinational
	logic                 in_fire;
	logic                 out_free;
	logic                 pop;
	logic                 busy;
	logic [AW-1:0]        head_inc;
	logic [AW-1:0]        tail_inc;
	logic [ARR_W-1:0]     arr_sum;
	logic [TIME_BITS-1:0] arr_sat;
	logic [CW-1:0]        cap_ext;
	logic [CW-1:0]        cap_clamp;
	logic [DIFF_W-1:0]    wait_diff;
	logic [DW-1:0]        qd_sat;
	logic [TIME_BITS:0]   dep_sum;
	logic [TIME_BITS-1:0] dep;
	logic [DW:0]          e2e_sum;
	logic [DW-1:0]        e2e_sat;
	logic                 ring_we;
	logic                 ring_re;
	logic [AW-1:0]        ring_raddr;
	logic [TIME_BITS-1:0] ring_rdata;
	logic [QC_W-1:0]      ring_span;

	// ---------------------------------------------------------------
	// handshakes: the output register parts the two sides, so a new item
	// is taken in the same cycle a finished result moves into it
	// ---------------------------------------------------------------
	assign out_free  = !out_valid_q || res.ready;
	assign pkt.ready = (state_q == ST_IDLE) || ((state_q == ST_EMIT) && out_free);
	assign in_fire   = pkt.valid && pkt.ready;

	// ring pointers wrap at the depth, which need not be a power of two
	assign head_inc = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == AW'(RING_DEPTH - 1)) ? '0 : tail_q + AW'(1);

	// ---------------------------------------------------------------
	// accept stage: arrival time, fixed delay part and clamped capacity
	// ---------------------------------------------------------------
	// send time above the time range and the add both saturate to the same limit
	assign arr_sum = ARR_W'(pkt.send_time) + ARR_W'(cfg.ingress);
	assign arr_sat = (arr_sum > TMAX_A) ? {TIME_BITS{1'b1}} : arr_sum[TIME_BITS-1:0];

	// a capacity of zero acts as one, anything beyond the ring acts as the ring depth
	assign cap_ext   = CW'(cfg.capacity);
	assign cap_clamp = (cap_ext == '0) ? CW'(1) :
		(cap_ext > CW'(RING_DEPTH)) ? CW'(RING_DEPTH) : cap_ext;

	// ---------------------------------------------------------------
	// scan stage: read head, retire while its departure is due, one per cycle
	// the read for the following head is issued in the same cycle as the pop
	// ---------------------------------------------------------------
	assign pop = (state_q == ST_SCAN) && (count_q != '0) && (ring_rdata <= arr_s1);

	// service waits behind the last departure only while something is queued
	assign busy      = (count_q != '0) && (last_q > arr_s1);
	assign wait_diff = DIFF_W'(last_q - arr_s1);
	assign qd_sat    = !busy ? '0 :
		(wait_diff > DMAX_D) ? {DW{1'b1}} : wait_diff[DW-1:0];

	// ---------------------------------------------------------------
	// finish stage: departure time, end-to-end delay, ring push
	// ---------------------------------------------------------------
	assign dep_sum = (TIME_BITS+1)'(start_s2) + (TIME_BITS+1)'(svc_s1);
	assign dep     = dep_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dep_sum[TIME_BITS-1:0];
	assign e2e_sum = (DW+1)'(qd_s2) + (DW+1)'(fixed_s1);
	assign e2e_sat = e2e_sum[DW] ? {DW{1'b1}} : e2e_sum[DW-1:0];

	// reads happen only on accept and in scan, writes only in finish, so
	// one entry is never read and written in the same cycle
	assign ring_we    = (state_q == ST_FINISH) && !drop_s2;
	assign ring_re    = in_fire || pop;
	assign ring_raddr = (state_q == ST_SCAN) ? head_inc : head_q;

	tdq_ring #(
		.DEPTH (RING_DEPTH),
		.WIDTH (TIME_BITS)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (tail_q),
		.wdata (dep),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	tdq_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// ---------------------------------------------------------------
	// emit stage: statistics advance as the result is loaded
	// ---------------------------------------------------------------
	assign upd.fire     = (state_q == ST_EMIT) && out_free;
	assign upd.accepted = acc_s3;
	assign upd.qd       = qd_s3;
	assign upd.e2e      = e2e_s3;

	tdq_stats #(
		.OCC_BITS (QC_W)
	) u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.occ      (count_q),
		.nxt      (stat_nxt),
		.peak_nxt (peak_nxt)
	);

	// sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pop) begin
						head_q  <= head_inc;
						count_q <= count_q - QC_W'(1);
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!drop_s2) begin
						tail_q  <= tail_inc;
						count_q <= count_q + QC_W'(1);
						last_q  <= dep;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= in_fire ? ST_SCAN : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload through the stages
	always_ff @(posedge clk) begin
		if (in_fire) begin
			arr_s1   <= arr_sat;
			fixed_s1 <= tdq_pkg::FIX_W'(cfg.ingress) + tdq_pkg::FIX_W'(cfg.service)
				+ tdq_pkg::FIX_W'(cfg.egress);
			svc_s1   <= cfg.service;
			cap_s1   <= QC_W'(cap_clamp);
		end
		if ((state_q == ST_SCAN) && !pop) begin
			start_s2 <= busy ? last_q : arr_s1;
			qd_s2    <= qd_sat;
			drop_s2  <= (count_q >= cap_s1);
		end
		if (state_q == ST_FINISH) begin
			acc_s3 <= !drop_s2;
			qd_s3  <= drop_s2 ? '0 : qd_s2;
			e2e_s3 <= drop_s2 ? '0 : e2e_sat;
		end
		if (upd.fire) begin
			acc_q  <= acc_s3;
			qd_q   <= qd_s3;
			e2e_q  <= e2e_s3;
			occ_q  <= tdq_pkg::OCC_W'(count_q);
			peak_q <= tdq_pkg::OCC_W'(peak_nxt);
			stat_q <= stat_nxt;
		end
	end

	assign res.valid                  = out_valid_q;
	assign res.accepted               = acc_q;
	assign res.queue_delay            = qd_q;
	assign res.end_to_end_delay       = e2e_q;
	assign res.occupancy              = occ_q;
	assign res.delivered_count        = stat_q.delivered;
	assign res.dropped_count          = stat_q.dropped;
	assign res.peak_occupancy         = peak_q;
	assign res.total_queue_delay      = stat_q.qd_sum;
	assign res.total_end_to_end_delay = stat_q.e2e_sum;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// distance from head to tail around the ring
	assign ring_span = (tail_q >= head_q) ? QC_W'(tail_q - head_q)
		: QC_W'(RING_DEPTH) - QC_W'(head_q) + QC_W'(tail_q);

	a_fire_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SCAN))
		else $error("accepted item did not start a scan");

	a_ring_span: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QC_W'(RING_DEPTH)) ? (head_q == tail_q)
			: ((count_q == ring_span) || ((count_q == '0) && (head_q == tail_q))))
		else $error("occupancy disagrees with ring pointers");

	a_head_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != $past(head_q)) |-> ($past(state_q) == ST_SCAN))
		else $error("head moved outside the scan stage");

	a_no_ring_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_we && ring_re))
		else $error("ring read and write in the same cycle");

endmodule

FILE: sim/tail_drop_queue_delay_model_core_checker.sv
`timescale 1ns / 100ps
// tail_drop_queue_delay_model_core_checker: watches the packet, result and register ports,
// predicts each result of the queue delay core and compares it field by field
// depends on tdq_pkg and tdq_if
module tail_drop_queue_delay_model_core_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	tdq_in_if                         pkt,
	tdq_out_if                        res,
	input  logic                      cfg_we,
	input  tdq_pkg::cfg_idx_t         cfg_index,
	input  logic [tdq_pkg::CFG_W-1:0] cfg_wdata,
	output int                        mismatches,
	output int                        outstanding,
	output int                        results_checked,
	output int                        drops_seen
);

	localparam int DEPTH = tdq_pkg::RING_DEPTH_DEF;
	localparam int AW    = $clog2(DEPTH);
	localparam int TBITS = tdq_pkg::TIME_BITS_DEF;
	localparam logic [63:0] TIME_TOP  = (64'd1 << TBITS) - 64'd1;
	localparam logic [63:0] DELAY_TOP = (64'd1 << tdq_pkg::DELAY_W) - 64'd1;
	localparam logic [63:0] SUM_TOP   = (64'd1 << tdq_pkg::SUM_W) - 64'd1;
	localparam logic [tdq_pkg::COUNT_W-1:0] COUNT_TOP = '1;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic                        accepted;
		logic [tdq_pkg::DELAY_W-1:0] queue_delay;
		logic [tdq_pkg::DELAY_W-1:0] end_to_end_delay;
		logic [tdq_pkg::OCC_W-1:0]   occupancy;
		logic [tdq_pkg::COUNT_W-1:0] delivered_count;
		logic [tdq_pkg::COUNT_W-1:0] dropped_count;
		logic [tdq_pkg::OCC_W-1:0]   peak_occupancy;
		logic [tdq_pkg::SUM_W-1:0]   total_queue_delay;
		logic [tdq_pkg::SUM_W-1:0]   total_end_to_end_delay;
	} outcome_t;

	// shadow registers and queue state
	tdq_pkg::cfg_t               regs;
	logic [TBITS-1:0]            departures [DEPTH];
	logic [AW-1:0]               head, tail;
	int unsigned                 held, peak;
	logic [63:0]                 last_departure;
	logic [tdq_pkg::COUNT_W-1:0] delivered_n, dropped_n;
	logic [63:0]                 qd_total, e2e_total;
	outcome_t                    expected_q [$];
	outcome_t                    want;

	function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] lim);
		logic [63:0] s;
		s = a + b;
		return (s > lim) ? lim : s;
	endfunction

	// one packet through the queue: retire, admit or drop, update statistics
	function automatic outcome_t admit_packet(input logic [tdq_pkg::SEND_W-1:0] send);
		int unsigned cap;
		logic [63:0] arrival, start, qd, e2e, dep;
		outcome_t o;
		cap = 32'(regs.capacity);
		if (cap < 1) cap = 1;
		if (cap > DEPTH) cap = DEPTH;
		arrival = add_capped({16'd0, send}, {32'd0, regs.ingress}, TIME_TOP);
		while (held > 0 && {16'd0, departures[head]} <= arrival) begin
			head = head + AW'(1);
			held--;
		end
		o = '0;
		if (held >= cap) begin
			if (dropped_n != COUNT_TOP) dropped_n++;
		end else begin
			start = (held == 0 || last_departure < arrival) ? arrival : last_departure;
			qd = start - arrival;
			if (qd > DELAY_TOP) qd = DELAY_TOP;
			e2e = add_capped(qd, {32'd0, regs.ingress}, DELAY_TOP);
			e2e = add_capped(e2e, {32'd0, regs.service}, DELAY_TOP);
			e2e = add_capped(e2e, {32'd0, regs.egress}, DELAY_TOP);
			dep = add_capped(start, {32'd0, regs.service}, TIME_TOP);
			departures[tail] = dep[TBITS-1:0];
			tail = tail + AW'(1);
			held++;
			last_departure = dep;
			if (delivered_n != COUNT_TOP) delivered_n++;
			qd_total = add_capped(qd_total, qd, SUM_TOP);
			e2e_total = add_capped(e2e_total, e2e, SUM_TOP);
			o.accepted = 1'b1;
			o.queue_delay = qd[tdq_pkg::DELAY_W-1:0];
			o.end_to_end_delay = e2e[tdq_pkg::DELAY_W-1:0];
		end
		if (held > peak) peak = held;
		o.occupancy = held[tdq_pkg::OCC_W-1:0];
		o.delivered_count = delivered_n;
		o.dropped_count = dropped_n;
		o.peak_occupancy = peak[tdq_pkg::OCC_W-1:0];
		o.total_queue_delay = qd_total[tdq_pkg::SUM_W-1:0];
		o.total_end_to_end_delay = e2e_total[tdq_pkg::SUM_W-1:0];
		return o;
	endfunction

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s", results_checked, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s got %0h expected %0h", name, got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.ingress = tdq_pkg::INGRESS_RST;
			regs.service = tdq_pkg::SERVICE_RST;
			regs.egress = tdq_pkg::EGRESS_RST;
			regs.capacity = tdq_pkg::CAPACITY_RST;
			head = '0;
			tail = '0;
			held = 0;
			peak = 0;
			last_departure = '0;
			delivered_n = '0;
			dropped_n = '0;
			qd_total = '0;
			e2e_total = '0;
			expected_q.delete();
			mismatches = 0;
			outstanding = 0;
			results_checked = 0;
			drops_seen = 0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tdq_pkg::CFG_INGRESS:  regs.ingress = cfg_wdata;
					tdq_pkg::CFG_SERVICE:  regs.service = cfg_wdata;
					tdq_pkg::CFG_EGRESS:   regs.egress = cfg_wdata;
					tdq_pkg::CFG_CAPACITY: regs.capacity = cfg_wdata[tdq_pkg::CAP_W-1:0];
				endcase
			end
			if (res.valid && res.ready) begin
				results_checked++;
				if (expected_q.size() == 0) begin
					report("result with no packet waiting for it");
				end else begin
					want = expected_q.pop_front();
					if (!want.accepted) drops_seen++;
					check_field("accepted", 64'(res.accepted), 64'(want.accepted));
					check_field("queue_delay", 64'(res.queue_delay), 64'(want.queue_delay));
					check_field("end_to_end_delay", 64'(res.end_to_end_delay),
						64'(want.end_to_end_delay));
					check_field("occupancy", 64'(res.occupancy), 64'(want.occupancy));
					check_field("delivered_count", 64'(res.delivered_count),
						64'(want.delivered_count));
					check_field("dropped_count", 64'(res.dropped_count),
						64'(want.dropped_count));
					check_field("peak_occupancy", 64'(res.peak_occupancy),
						64'(want.peak_occupancy));
					check_field("total_queue_delay", 64'(res.total_queue_delay),
						64'(want.total_queue_delay));
					check_field("total_end_to_end_delay", 64'(res.total_end_to_end_delay),
						64'(want.total_end_to_end_delay));
				end
			end
			if (pkt.valid && pkt.ready)
				expected_q.push_back(admit_packet(pkt.send_time));
			outstanding = expected_q.size();
		end
	end

endmodule

FILE: sim/tail_drop_queue_delay_model_core_tb.sv
`timescale 1ns / 100ps
// tail_drop_queue_delay_model_core_tb: drives packets and register writes into the
// queue delay core and gives the verdict; depends on tdq_pkg, tdq_if, the core and its checker
module tail_drop_queue_delay_model_core_tb;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1380;
	localparam int PHASES       = 8;
	localparam int TAIL_CYCLES  = 70;
	localparam logic [tdq_pkg::SEND_W-1:0] TIME_TOP = '1;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	tdq_pkg::cfg_idx_t           cfg_index;
	logic [tdq_pkg::CFG_W-1:0]   cfg_wdata;

	// idling percentages, changed per phase
	int                   send_idle_pct;
	int                   stall_pct;
	int                   packets_sent;
	int                   settings_used;
	int                   cycle_count;

	// running send time of the well-ordered stream and the current service time
	logic [63:0]          time_cursor;
	logic [63:0]          service_now;

	int                   mismatches;
	int                   outstanding;
	int                   results_checked;
	int                   drops_seen;

	tdq_in_if  pkt_ch ();
	tdq_out_if res_ch ();

	tail_drop_queue_delay_model_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tail_drop_queue_delay_model_core_checker queue_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.pkt             (pkt_ch),
		.res             (res_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.drops_seen      (drops_seen)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side back-pressure, redrawn every cycle
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= stall_pct);

	// idling patterns: none, sender gaps, receiver stalls, both
	task automatic set_idling(input int mode);
		unique case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 53;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 53;
			end
			default: begin
				send_idle_pct = 36;
				stall_pct = 36;
			end
		endcase
	endtask

	// one register write; the enable is dropped again afterwards
	task automatic write_reg(input tdq_pkg::cfg_idx_t idx,
			input logic [tdq_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_registers(input logic [tdq_pkg::CFG_W-1:0] ingress,
			input logic [tdq_pkg::CFG_W-1:0] service, input logic [tdq_pkg::CFG_W-1:0] egress,
			input logic [tdq_pkg::CFG_W-1:0] cap_word);
		write_reg(tdq_pkg::CFG_INGRESS, ingress);
		write_reg(tdq_pkg::CFG_SERVICE, service);
		write_reg(tdq_pkg::CFG_EGRESS, egress);
		write_reg(tdq_pkg::CFG_CAPACITY, cap_word);
		service_now = {32'd0, service};
		settings_used++;
	endtask

	// offer one packet, with random idle cycles first, and hold it until taken
	task automatic push_packet(input logic [tdq_pkg::SEND_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			pkt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.send_time <= t;
		@(posedge clk);
		while (!(pkt_ch.valid && pkt_ch.ready)) @(posedge clk);
		packets_sent++;
		@(negedge clk);
	endtask

	// block idle: every result back, then a short pause before any register write
	task automatic wait_drained();
		pkt_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly a non-decreasing stream with gaps scaled to the service time, so the
	// queue fills, drops and drains; a few packets go back in time or repeat a time
	function automatic logic [tdq_pkg::SEND_W-1:0] next_send_time();
		logic [63:0] wide;
		logic [63:0] gap;
		int unsigned pick;
		pick = $urandom_range(99);
		wide = {$urandom, $urandom};
		if (pick < 6)
			return (time_cursor == 0) ? '0 : tdq_pkg::SEND_W'(wide % time_cursor);
		if (pick < 10) return time_cursor[tdq_pkg::SEND_W-1:0];
		pick = $urandom_range(99);
		if (pick < 45)
			gap = wide % (service_now + 64'd1);
		else if (pick < 85)
			gap = service_now + wide % (service_now + 64'd1);
		else
			gap = service_now * 64'($urandom_range(80, 2)) + 64'($urandom_range(100, 0));
		time_cursor += gap;
		return time_cursor[tdq_pkg::SEND_W-1:0];
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tdq_pkg::CFG_INGRESS;
		cfg_wdata = '0;
		pkt_ch.valid = 1'b0;
		pkt_ch.send_time = '0;
		packets_sent = 0;
		settings_used = 0;
		time_cursor = '0;
		service_now = 64'd1;
		set_idling(0);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset registers, empty queue then a queued packet at time zero
		push_packet('0);
		push_packet('0);
		push_packet(48'd1);
		push_packet(48'd1);
		wait_drained();

		// capacity zero behaves as one: drop while full, retire on an exact departure,
		// then an earlier send time against a full queue
		set_registers(32'd3, 32'd10, 32'd2, 32'd0);
		push_packet(48'd100);
		push_packet(48'd100);
		push_packet(48'd110);
		push_packet(48'd50);
		wait_drained();

		// capacity three: an earlier send time still queues behind the last departure
		set_registers(32'd3, 32'd10, 32'd2, 32'd3);
		push_packet(48'd200);
		push_packet(48'd200);
		push_packet(48'd150);
		push_packet(48'd200);
		wait_drained();

		// capacity lowered below what is held: drop, then retire and admit
		write_reg(tdq_pkg::CFG_CAPACITY, 32'd1);
		push_packet(48'd200);
		push_packet(48'd260);
		wait_drained();

		// all-ones registers, capacity above the ring depth, time and delay saturation
		set_registers('1, '1, '1, 32'd127);
		push_packet(TIME_TOP);
		push_packet('0);
		push_packet('0);
		push_packet(TIME_TOP - 48'd5);
		push_packet(TIME_TOP);
		wait_drained();

		// random phases, each with its own registers and idling pattern
		for (int p = 0; p < PHASES; p++) begin
			set_idling(p % 4);
			unique case (p)
				0: set_registers('0, '0, '0, '0);
				1: set_registers($urandom_range(1000, 0), $urandom_range(20, 1),
					$urandom_range(50, 0), $urandom_range(8, 1));
				2: set_registers($urandom_range(100, 0), $urandom_range(5, 1),
					$urandom_range(10, 0), 32'd64);
				3: set_registers($urandom, $urandom, $urandom, 32'd127);
				4: set_registers($urandom_range(20, 0), $urandom_range(12, 4), '0, 32'd64);
				5: set_registers($urandom_range(20, 0), $urandom_range(12, 4), '0, 32'd2);
				6: set_registers('1, $urandom_range(300, 1), '1, $urandom_range(64, 1));
				default: set_registers($urandom, $urandom_range(1000, 0), $urandom, $urandom);
			endcase
			// a long jump empties the queue, except where a smaller capacity
			// is meant to land on a queue left full
			if (p != 5) time_cursor += 64'd1 << 40;
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
				push_packet(next_send_time());
			wait_drained();
		end

		// last: departures pinned at the top of time, early packets queue behind them,
		// so both delay sums run into saturation
		set_idling(3);
		set_registers('0, 32'h1000, '0, 32'd64);
		for (int r = 0; r < 5; r++) begin
			push_packet(TIME_TOP);
			repeat (70) push_packet(tdq_pkg::SEND_W'($urandom_range(1000, 0)));
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("summary: %0d packets over %0d register settings and all four idling patterns",
			packets_sent, settings_used);
		$display("summary: %0d results compared, %0d of them drops, %0d mismatches",
			results_checked, drops_seen, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
